>>> sv/distance_bar_and_beep_controller_unit_macros.svh
// Assertion macros shared by the controller RTL.
`ifndef DISTANCE_BAR_AND_BEEP_CONTROLLER_UNIT_MACROS_SVH
`define DISTANCE_BAR_AND_BEEP_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTH
`define DBBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DBBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DBBC_ASSERT_SAME(label, ante, cons)
`define DBBC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/dbbc_pkg.sv
package dbbc_pkg;

  typedef enum logic [1:0] {
    OP_RX_BYTE    = 2'd0,
    OP_FRAME_EDGE = 2'd1,
    OP_BEEP_TICK  = 2'd2,
    OP_SCAN_TICK  = 2'd3
  } op_e;

  localparam logic [3:0] SILENCE_RESET = 4'd14;
  localparam logic [3:0] LEVEL_RESET   = 4'd15;
  localparam logic [3:0] PORT_C_RESET  = 4'hF;
  localparam logic [7:0] PORT_D_RESET  = 8'hFF;
  localparam logic [3:0] PORT_B_RESET  = 4'hF;
  localparam logic [1:0] BYTE_IDX_DONE = 2'd2;

  typedef struct packed {
    logic [3:0] port_b_low;
    logic [7:0] port_d;
    logic [3:0] port_c_low;
    logic       beeper_on;
  } result_t;

  function automatic logic [6:0] left_bar(input logic [3:0] level);
    logic [6:0] bar;
    unique case (level[3:1])
      3'd0:    bar = 7'h00;
      3'd1:    bar = 7'h40;
      3'd2:    bar = 7'h60;
      3'd3:    bar = 7'h70;
      3'd4:    bar = 7'h78;
      3'd5:    bar = 7'h7C;
      3'd6:    bar = 7'h7E;
      default: bar = 7'h7F;
    endcase
    return bar;
  endfunction

  function automatic logic [7:0] right_bar(input logic [3:0] level);
    logic [7:0] bar;
    unique case (level[3:1])
      3'd0:    bar = 8'h00;
      3'd1:    bar = 8'h02;
      3'd2:    bar = 8'h06;
      3'd3:    bar = 8'h0E;
      3'd4:    bar = 8'h1E;
      3'd5:    bar = 8'h3E;
      3'd6:    bar = 8'h7E;
      default: bar = 8'hFE;
    endcase
    return bar;
  endfunction

  function automatic logic [3:0] level_of(input logic [7:0] rx_byte);
    return rx_byte[7] ? 4'd15 : rx_byte[6:3];
  endfunction

endpackage

>>> sv/dbbc_core.sv
module dbbc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              valid_i,
  input  dbbc_pkg::op_e     op_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_pin_i,
  output dbbc_pkg::result_t result_o
);

  logic [3:0] silence_q;
  logic [3:0] left_q, left_d;
  logic [3:0] right_q, right_d;
  logic [1:0] byte_idx_q, byte_idx_d;
  logic       rx_en_q, rx_en_d;
  logic [3:0] beep_cnt_q, beep_cnt_d;
  logic       beeper_q, beeper_d;
  logic [3:0] scan_idx_q, scan_idx_d;
  logic [3:0] port_c_q, port_c_d;
  logic [7:0] port_d_q, port_d_d;
  logic [3:0] port_b_q, port_b_d;

  logic [3:0]  limit;
  logic [3:0]  cnt;
  logic [4:0]  cnt_inc;
  logic [6:0]  lb;
  logic [7:0]  rb;
  logic [15:0] mask;

  assign limit   = (right_q < left_q) ? right_q : left_q;
  assign cnt     = (left_q >= silence_q && right_q >= silence_q) ? 4'd1 : beep_cnt_q;
  assign cnt_inc = {1'b0, cnt} + 5'd1;
  assign lb      = dbbc_pkg::left_bar(left_q);
  assign rb      = dbbc_pkg::right_bar(right_q);
  assign mask    = ~(16'd1 << scan_idx_q);

  always_comb begin
    left_d     = left_q;
    right_d    = right_q;
    byte_idx_d = byte_idx_q;
    rx_en_d    = rx_en_q;
    beep_cnt_d = beep_cnt_q;
    beeper_d   = beeper_q;
    scan_idx_d = scan_idx_q;
    port_c_d   = port_c_q;
    port_d_d   = port_d_q;
    port_b_d   = port_b_q;
    if (valid_i) begin
      unique case (op_i)
        dbbc_pkg::OP_RX_BYTE: begin
          if (rx_en_q) begin
            if (byte_idx_q == 2'd0) begin
              left_d = dbbc_pkg::level_of(rx_byte_i);
            end else if (byte_idx_q == 2'd1) begin
              right_d = dbbc_pkg::level_of(rx_byte_i);
              rx_en_d = 1'b0;
            end
            if (byte_idx_q < dbbc_pkg::BYTE_IDX_DONE) begin
              byte_idx_d = byte_idx_q + 2'd1;
            end
          end
        end
        dbbc_pkg::OP_FRAME_EDGE: begin
          byte_idx_d = 2'd0;
          rx_en_d    = ~frame_pin_i;
        end
        dbbc_pkg::OP_BEEP_TICK: begin
          if (cnt == 4'd0) begin
            beeper_d = 1'b1;
          end else if (cnt == 4'd1) begin
            beeper_d = 1'b0;
          end
          beep_cnt_d = (cnt_inc >= {1'b0, limit}) ? 4'd0 : cnt_inc[3:0];
        end
        dbbc_pkg::OP_SCAN_TICK: begin
          port_c_d   = lb[3:0] | mask[3:0];
          port_d_d   = {rb[3:0], 1'b0, lb[6:4]} | mask[11:4];
          port_b_d   = rb[7:4] | mask[15:12];
          scan_idx_d = scan_idx_q + 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q  <= dbbc_pkg::SILENCE_RESET;
      left_q     <= dbbc_pkg::LEVEL_RESET;
      right_q    <= dbbc_pkg::LEVEL_RESET;
      byte_idx_q <= 2'd0;
      rx_en_q    <= 1'b0;
      beep_cnt_q <= 4'd0;
      beeper_q   <= 1'b0;
      scan_idx_q <= 4'd0;
      port_c_q   <= dbbc_pkg::PORT_C_RESET;
      port_d_q   <= dbbc_pkg::PORT_D_RESET;
      port_b_q   <= dbbc_pkg::PORT_B_RESET;
    end else begin
      if (cfg_we_i) begin
        silence_q <= cfg_wdata_i;
      end
      left_q     <= left_d;
      right_q    <= right_d;
      byte_idx_q <= byte_idx_d;
      rx_en_q    <= rx_en_d;
      beep_cnt_q <= beep_cnt_d;
      beeper_q   <= beeper_d;
      scan_idx_q <= scan_idx_d;
      port_c_q   <= port_c_d;
      port_d_q   <= port_d_d;
      port_b_q   <= port_b_d;
    end
  end

  assign result_o.beeper_on  = beeper_d;
  assign result_o.port_c_low = port_c_d;
  assign result_o.port_d     = port_d_d;
  assign result_o.port_b_low = port_b_d;

endmodule

>>> sv/distance_bar_and_beep_controller_unit.sv
// Distance bar and beep controller. Each input transfer carries one event
// (serial byte, frame pin edge, beep tick or scan tick) and yields exactly one
// result transfer with the beeper state and the three port values after that
// event. One event is accepted every cycle while the skid register is empty.
// The controller state is updated by a single combinational pass between the
// state registers and a two-entry output buffer (output and skid register),
// which holds each result; a stalled master side holds up the slave side only
// once that buffer is full. The silence level may be written at any cycle
// with no events in flight and takes effect for the next event.
`include "distance_bar_and_beep_controller_unit_macros.svh"

module distance_bar_and_beep_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from the lowest: rx_byte[7:0], frame_pin, zero fill.
  input  logic [15:0] s_axis_tdata,
  // Bits from the lowest: op[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from the lowest: beeper_on, port_c_low[3:0], port_d[7:0],
  // port_b_low[3:0], zero fill.
  output logic [23:0] m_axis_tdata
);

  logic              in_fire;
  logic              out_fire;
  dbbc_pkg::result_t result;
  dbbc_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign s_axis_tready = ~skid_valid_q;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = out_valid_q & m_axis_tready;

  dbbc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (in_fire),
    .op_i        (dbbc_pkg::op_e'(s_axis_tuser)),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .frame_pin_i (s_axis_tdata[8]),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= result;
      end
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

  `DBBC_ASSERT_SAME(a_skid_implies_out, skid_valid_q, out_valid_q)
  `DBBC_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_valid_q && !m_axis_tready,
                    skid_valid_q)
  `DBBC_ASSERT_NEXT(a_skid_holds, skid_valid_q && !m_axis_tready,
                    skid_valid_q && $stable(skid_q))

endmodule
